// ----- src/nrts_pkg.sv -----
// shared types and constants for the nested range table search block
package nrts_pkg;
	localparam int unsigned DEPTH = 4096;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned PW = 31;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_RESET = 3'd1;
	localparam logic [2:0] OP_NEXT = 3'd2;
	localparam logic [2:0] OP_FBEG = 3'd3;
	localparam logic [2:0] OP_FEND = 3'd4;
	localparam logic [2:0] OP_CONT = 3'd5;

	typedef struct packed {
		logic [PW-1:0] beg;
		logic [PW-1:0] fin;
		logic nested;
	} entry_t;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_GUP    = 15'b000000000000010,
		S_GUPW   = 15'b000000000000100,
		S_GDN    = 15'b000000000001000,
		S_GDNW   = 15'b000000000010000,
		S_FIX    = 15'b000000000100000,
		S_FIXW   = 15'b000000001000000,
		S_SCAN   = 15'b000000010000000,
		S_SCANW  = 15'b000000100000000,
		S_CW     = 15'b000001000000000,
		S_CWW    = 15'b000010000000000,
		S_CPREV  = 15'b000100000000000,
		S_CPREVW = 15'b001000000000000,
		S_OUT    = 15'b010000000000000,
		S_OUTW   = 15'b100000000000000
	} state_t;
endpackage

// ----- src/nrts_ram.sv -----
// single port range table memory with registered read
module nrts_ram (
	input  logic clk,
	input  logic we,
	input  logic [nrts_pkg::AW-1:0] addr,
	input  nrts_pkg::entry_t wdata,
	output nrts_pkg::entry_t rdata
);
	nrts_pkg::entry_t mem [nrts_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/nested_range_table_search.sv -----
// top level of the nested range table search block
// sequence: write, reset, next and unused codes go straight to the output reads (final entry,
//   then cursor entry) before the result strobe; find and containing first gallop over the
//   table, about 2*log2(count) gallop reads plus the scan lengths, each a table read
// throughput: one command at a time, busy high from the accepting edge until the result strobe
// the single table port bounds the rate; each probe is a read then a compare
// reset clears cursor to 0 and count to 1; table contents are undefined until written
module nested_range_table_search (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [2:0] op,
	input  logic [11:0] entry_index,
	input  logic [30:0] entry_begin,
	input  logic [30:0] entry_end,
	input  logic entry_nested,
	input  logic [30:0] position,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [12:0] cfg_data,
	output logic done,
	output logic [30:0] range_begin,
	output logic [30:0] range_end,
	output logic [12:0] cursor_index,
	output logic exhausted,
	output logic found,
	output logic [11:0] found_index
);
	localparam int unsigned AW = nrts_pkg::AW;
	localparam int unsigned CW = nrts_pkg::CW;

	nrts_pkg::state_t state_q;
	logic [CW-1:0] count_q, cursor_q, cur_q, start_q, inc_q, w_q, best_q;
	logic [2:0] op_q;
	logic [31:0] pos_q, size_q;
	logic [31:0] fin_q;
	logic fin_ok_q;
	logic is_end_q, phase_q;
	logic found_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	nrts_pkg::entry_t wdata, rd;

	logic [CW-1:0] eff;
	logic [CW:0] probe;
	logic [31:0] key, rb, re;
	logic in_rng;

	always_comb begin
		eff = cfg_data;
		if (cfg_data == '0) eff = CW'(1);
		if (cfg_data > CW'(nrts_pkg::DEPTH)) eff = CW'(nrts_pkg::DEPTH);
	end

	assign wdata = '{beg: entry_begin, fin: entry_end, nested: entry_nested};
	assign rb = {1'b0, rd.beg};
	assign re = {1'b0, rd.fin};
	assign key = is_end_q ? re : rb;
	assign probe = {1'b0, cur_q} + {1'b0, inc_q};
	assign in_rng = w_q < count_q;

	assign busy = (state_q != nrts_pkg::S_IDLE);
	assign cfg_ready = !busy && !start;

	nrts_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wdata), .rdata(rd));

	always_comb begin
		ram_we = 1'b0;
		ram_addr = '0;
		unique case (state_q)
			nrts_pkg::S_IDLE: begin
				ram_we = start && op == nrts_pkg::OP_WRITE;
				ram_addr = entry_index;
			end
			nrts_pkg::S_GUP, nrts_pkg::S_GDN: ram_addr = probe[AW-1:0];
			nrts_pkg::S_FIX, nrts_pkg::S_SCAN: ram_addr = cur_q[AW-1:0];
			nrts_pkg::S_CW: ram_addr = fin_ok_q ? w_q[AW-1:0] : AW'(count_q - 1'b1);
			nrts_pkg::S_CPREV: ram_addr = w_q[AW-1:0];
			nrts_pkg::S_OUT: ram_addr = phase_q ? cursor_q[AW-1:0] : AW'(count_q - 1'b1);
			default: ram_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrts_pkg::S_IDLE;
			count_q <= CW'(1);
			cursor_q <= '0;
			done <= 1'b0;
			fin_ok_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				nrts_pkg::S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						count_q <= eff;
						if (cursor_q > eff) cursor_q <= eff;
					end
					if (start) begin
						op_q <= op;
						pos_q <= {1'b0, position};
						found_q <= 1'b0;
						best_q <= '0;
						phase_q <= 1'b0;
						cur_q <= cursor_q;
						start_q <= cursor_q;
						inc_q <= CW'(1);
						is_end_q <= (op == nrts_pkg::OP_FEND);
						state_q <= nrts_pkg::S_OUT;
						unique case (op)
							nrts_pkg::OP_RESET: cursor_q <= '0;
							nrts_pkg::OP_NEXT:
								if (cursor_q < count_q) cursor_q <= cursor_q + 1'b1;
							nrts_pkg::OP_FBEG, nrts_pkg::OP_FEND:
								if (cursor_q < count_q) state_q <= nrts_pkg::S_GUP;
							nrts_pkg::OP_CONT: begin
								cur_q <= '0;
								start_q <= '0;
								is_end_q <= 1'b1;
								pos_q <= {1'b0, position} + 32'd1;
								state_q <= nrts_pkg::S_GUP;
							end
							default: ;
						endcase
					end
				end
				nrts_pkg::S_GUP: begin
					if (probe < {1'b0, count_q}) state_q <= nrts_pkg::S_GUPW;
					else state_q <= nrts_pkg::S_GDN;
				end
				nrts_pkg::S_GUPW: begin
					if (key <= pos_q) begin
						cur_q <= probe[CW-1:0];
						inc_q <= inc_q << 1;
						state_q <= nrts_pkg::S_GUP;
					end else state_q <= nrts_pkg::S_GDN;
				end
				nrts_pkg::S_GDN: begin
					if (inc_q == '0) state_q <= nrts_pkg::S_FIX;
					else if (probe < {1'b0, count_q}) state_q <= nrts_pkg::S_GDNW;
					else inc_q <= inc_q >> 1;
				end
				nrts_pkg::S_GDNW: begin
					if (key <= pos_q) cur_q <= probe[CW-1:0];
					inc_q <= inc_q >> 1;
					state_q <= nrts_pkg::S_GDN;
				end
				nrts_pkg::S_FIX: state_q <= nrts_pkg::S_FIXW;
				nrts_pkg::S_FIXW: begin
					// find begin: rd is entry cur, also in the back scan
					if (!is_end_q) begin
						if (!phase_q) begin
							if (rb < pos_q) begin
								cursor_q <= cur_q + 1'b1;
								state_q <= nrts_pkg::S_OUT;
							end else if (start_q < cur_q) begin
								phase_q <= 1'b1;
								cur_q <= cur_q - 1'b1;
								state_q <= nrts_pkg::S_FIX;
							end else begin
								cursor_q <= cur_q;
								state_q <= nrts_pkg::S_OUT;
							end
						end else begin
							if (rb == pos_q && start_q < cur_q) begin
								cur_q <= cur_q - 1'b1;
								state_q <= nrts_pkg::S_FIX;
							end else begin
								cursor_q <= (rb == pos_q) ? cur_q : cur_q + 1'b1;
								phase_q <= 1'b0;
								state_q <= nrts_pkg::S_OUT;
							end
						end
					end else begin
						if (start_q < cur_q && rd.nested) begin
							cur_q <= cur_q - 1'b1;
							state_q <= nrts_pkg::S_FIX;
						end else state_q <= nrts_pkg::S_SCAN;
					end
				end
				nrts_pkg::S_SCAN: begin
					if (cur_q < count_q) state_q <= nrts_pkg::S_SCANW;
					else if (op_q == nrts_pkg::OP_CONT) begin
						w_q <= cur_q;
						state_q <= nrts_pkg::S_CW;
					end else begin
						cursor_q <= cur_q;
						state_q <= nrts_pkg::S_OUT;
					end
				end
				nrts_pkg::S_SCANW: begin
					if (re < pos_q) begin
						cur_q <= cur_q + 1'b1;
						state_q <= nrts_pkg::S_SCAN;
					end else if (op_q == nrts_pkg::OP_CONT) begin
						w_q <= cur_q;
						phase_q <= 1'b0;
						pos_q <= pos_q - 32'd1;
						state_q <= nrts_pkg::S_CW;
					end else begin
						cursor_q <= cur_q;
						state_q <= nrts_pkg::S_OUT;
					end
				end
				nrts_pkg::S_CW: begin
					if (!fin_ok_q) state_q <= nrts_pkg::S_CWW;
					else if (!in_rng) begin
						if (!phase_q) state_q <= nrts_pkg::S_OUT;
						else begin
							found_q <= 1'b1;
							state_q <= nrts_pkg::S_OUT;
						end
					end else state_q <= nrts_pkg::S_CWW;
				end
				nrts_pkg::S_CWW: begin
					if (!fin_ok_q) begin
						// fetch final entry first
						fin_q <= re + 32'd1;
						fin_ok_q <= 1'b1;
						state_q <= nrts_pkg::S_CW;
					end else if (!phase_q) begin
						if (rb >= fin_q) state_q <= nrts_pkg::S_OUT;
						else if (rb <= pos_q) begin
							best_q <= w_q;
							size_q <= re - rb;
							phase_q <= 1'b1;
							w_q <= w_q + 1'b1;
							state_q <= nrts_pkg::S_CW;
						end else if (rb == re && rb == pos_q + 32'd1) begin
							best_q <= w_q;
							found_q <= 1'b1;
							state_q <= nrts_pkg::S_OUT;
						end else begin
							if (w_q != '0) w_q <= w_q - 1'b1;
							state_q <= nrts_pkg::S_CPREV;
						end
					end else begin
						if (rb != fin_q && rd.nested && rb <= pos_q) begin
							if (re > pos_q && $signed(re - rb) < $signed(size_q)) begin
								best_q <= w_q;
								size_q <= re - rb;
							end
							w_q <= w_q + 1'b1;
							state_q <= nrts_pkg::S_CW;
						end else begin
							found_q <= 1'b1;
							state_q <= nrts_pkg::S_OUT;
						end
					end
				end
				nrts_pkg::S_CPREV: state_q <= nrts_pkg::S_CPREVW;
				nrts_pkg::S_CPREVW: begin
					if (in_rng && rb == re && rb == pos_q) begin
						best_q <= w_q;
						found_q <= 1'b1;
					end else if (!in_rng && fin_q == pos_q) begin
						best_q <= w_q;
						found_q <= 1'b1;
					end
					state_q <= nrts_pkg::S_OUT;
				end
				nrts_pkg::S_OUT: state_q <= nrts_pkg::S_OUTW;
				nrts_pkg::S_OUTW: begin
					if (!phase_q) begin
						fin_q <= re + 32'd1;
						fin_ok_q <= 1'b1;
						phase_q <= 1'b1;
						state_q <= nrts_pkg::S_OUT;
					end else begin
						if (cursor_q < count_q) begin
							range_begin <= rd.beg;
							range_end <= rd.fin;
						end else begin
							range_begin <= fin_q[31] ? 31'h7FFFFFFF : fin_q[30:0];
							range_end <= fin_q[31] ? 31'h7FFFFFFF : fin_q[30:0];
						end
						cursor_index <= cursor_q;
						exhausted <= !(cursor_q < count_q);
						found <= found_q;
						found_index <= found_q ? best_q[AW-1:0] : '0;
						done <= 1'b1;
						fin_ok_q <= 1'b0;
						state_q <= nrts_pkg::S_IDLE;
					end
				end
				default: state_q <= nrts_pkg::S_IDLE;
			endcase
		end
	end

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q) else $error("cursor beyond count");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CW'(nrts_pkg::DEPTH)) else $error("bad count");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("strobe without command");
endmodule

// ----- tb/tb_top.sv -----
// testbench for nested_range_table_search: builds range tables, runs queries, checks each result
`timescale 1ns / 100ps
module tb_top;
	typedef struct {
		logic [30:0] rbeg;
		logic [30:0] rend;
		logic [12:0] cidx;
		logic ex;
		logic fnd;
		logic [11:0] fidx;
	} lookup_t;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam longint MAXPOS = 64'h7FFFFFFF;

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, done;
	logic [2:0] op;
	logic [11:0] entry_index;
	logic [30:0] entry_begin, entry_end, position;
	logic entry_nested;
	logic [12:0] cfg_data;
	logic [30:0] range_begin, range_end;
	logic [12:0] cursor_index;
	logic exhausted, found;
	logic [11:0] found_index;

	longint tbl_beg[nrts_pkg::DEPTH];
	longint tbl_end[nrts_pkg::DEPTH];
	bit tbl_nst[nrts_pkg::DEPTH];
	longint cur_pos;
	longint range_cnt;
	lookup_t lookups_due[$];
	int mismatches;
	bit quiet;

	nested_range_table_search dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.entry_index(entry_index), .entry_begin(entry_begin), .entry_end(entry_end),
		.entry_nested(entry_nested), .position(position), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
		.range_begin(range_begin), .range_end(range_end), .cursor_index(cursor_index),
		.exhausted(exhausted), .found(found), .found_index(found_index)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint eff_cnt();
		longint c;
		c = range_cnt;
		if (c == 0) c = 1;
		if (c > longint'(nrts_pkg::DEPTH)) c = longint'(nrts_pkg::DEPTH);
		return c;
	endfunction

	function automatic longint final_at();
		return tbl_end[eff_cnt() - 1] + 1;
	endfunction

	function automatic longint beg_at(longint i);
		return i < eff_cnt() ? tbl_beg[i] : final_at();
	endfunction

	function automatic longint end_at(longint i);
		return i < eff_cnt() ? tbl_end[i] : final_at();
	endfunction

	function automatic longint gallop_to_begin(longint c, longint p);
		longint last, st, inc;
		last = eff_cnt();
		st = c;
		inc = 1;
		if (c >= last) return c;
		while (c + inc < last && tbl_beg[c + inc] <= p) begin
			c += inc;
			inc *= 2;
		end
		while (inc > 0) begin
			if (c + inc < last && tbl_beg[c + inc] <= p) c += inc;
			inc /= 2;
		end
		if (tbl_beg[c] < p) begin
			c++;
		end else begin
			while (st < c && tbl_beg[c - 1] == p) c--;
		end
		return c;
	endfunction

	function automatic longint gallop_to_end(longint c, longint p);
		longint last, st, inc;
		last = eff_cnt();
		st = c;
		inc = 1;
		if (c >= last) return c;
		while (c + inc < last && tbl_end[c + inc] <= p) begin
			c += inc;
			inc *= 2;
		end
		while (inc > 0) begin
			if (c + inc < last && tbl_end[c + inc] <= p) c += inc;
			inc /= 2;
		end
		while (st < c && tbl_nst[c]) c--;
		while (c < last && tbl_end[c] < p) c++;
		return c;
	endfunction

	function automatic bit covering_range(longint p, output longint idx);
		longint fin, w, best, sz, s;
		fin = final_at();
		idx = 0;
		w = gallop_to_end(0, p + 1);
		if (beg_at(w) >= fin) return 0;
		if (beg_at(w) <= p) begin
			best = w;
			sz = end_at(w) - beg_at(w);
			w++;
			while (beg_at(w) != fin && w < eff_cnt() && tbl_nst[w] && beg_at(w) <= p) begin
				s = end_at(w) - beg_at(w);
				if (end_at(w) > p && s < sz) begin
					best = w;
					sz = s;
				end
				w++;
			end
			idx = best;
			return 1;
		end
		if (beg_at(w) == end_at(w) && beg_at(w) == p + 1) begin
			idx = w;
			return 1;
		end
		if (w > 0) w--;
		if (beg_at(w) == end_at(w) && beg_at(w) == p) begin
			idx = w;
			return 1;
		end
		return 0;
	endfunction

	function automatic longint sat31(longint v);
		return v > MAXPOS ? MAXPOS : v;
	endfunction

	task automatic predict_lookup(input logic [2:0] o, input logic [11:0] slot,
			input logic [30:0] b, input logic [30:0] e, input logic n, input logic [30:0] p);
		lookup_t r;
		bit f;
		longint fi;
		f = 0;
		fi = 0;
		case (o)
			nrts_pkg::OP_WRITE: begin
				tbl_beg[slot] = longint'(b);
				tbl_end[slot] = longint'(e);
				tbl_nst[slot] = n;
			end
			nrts_pkg::OP_RESET: cur_pos = 0;
			nrts_pkg::OP_NEXT: if (cur_pos < eff_cnt()) cur_pos++;
			nrts_pkg::OP_FBEG: cur_pos = gallop_to_begin(cur_pos, longint'(p));
			nrts_pkg::OP_FEND: cur_pos = gallop_to_end(cur_pos, longint'(p));
			nrts_pkg::OP_CONT: begin
				f = covering_range(longint'(p), fi);
				if (!f) fi = 0;
			end
			default: ;
		endcase
		r.rbeg = 31'(sat31(beg_at(cur_pos)));
		r.rend = 31'(sat31(end_at(cur_pos)));
		r.cidx = 13'(cur_pos);
		r.ex = cur_pos >= eff_cnt();
		r.fnd = f;
		r.fidx = 12'(fi);
		lookups_due.push_back(r);
	endtask

	task automatic maybe_idle();
		while (!quiet && $urandom_range(0, 99) < 16) @(posedge clk);
	endtask

	task automatic send_cmd(input logic [2:0] o, input logic [11:0] slot = 0,
			input logic [30:0] b = 0, input logic [30:0] e = 0, input logic n = 0,
			input logic [30:0] p = 0);
		maybe_idle();
		@(posedge clk);
		start <= 1'b1;
		op <= o;
		entry_index <= slot;
		entry_begin <= b;
		entry_end <= e;
		entry_nested <= n;
		position <= p;
		do @(posedge clk); while (busy);
		predict_lookup(o, slot, b, e, n, p);
		start <= 1'b0;
	endtask

	task automatic set_count(input logic [12:0] v);
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		range_cnt = longint'(v);
		if (cur_pos > eff_cnt()) cur_pos = eff_cnt();
		cfg_valid <= 1'b0;
	endtask

	task automatic build_table(input int n);
		longint p, b, e, pb, pe;
		bit nst;
		p = $urandom_range(0, 20);
		pb = 0;
		pe = 0;
		for (int i = 0; i < n; i++) begin
			nst = i > 0 && $urandom_range(0, 3) == 0;
			if (nst) begin
				b = pb + $urandom_range(0, 4);
				if (b > pe) b = pe;
				e = b + $urandom_range(0, 4);
				if (e > pe) e = pe;
			end else begin
				b = p + $urandom_range(0, 3);
				e = b + $urandom_range(0, 6);
				p = e;
				pb = b;
				pe = e;
			end
			send_cmd(nrts_pkg::OP_WRITE, 12'(i), 31'(b), 31'(e), nst);
		end
	endtask

	function automatic logic [30:0] pick_position();
		longint i, v;
		i = $urandom_range(0, 32'(eff_cnt() - 1));
		case ($urandom_range(0, 5))
			0: v = tbl_beg[i];
			1: v = tbl_end[i];
			2: v = tbl_beg[i] + 1 - $urandom_range(0, 2);
			3: v = tbl_end[i] + 1 - $urandom_range(0, 2);
			4: v = $urandom_range(0, 2147483646);
			default: v = $urandom_range(0, 40) + tbl_beg[0];
		endcase
		if (v < 0) v = 0;
		if (v > MAXPOS - 1) v = MAXPOS - 1;
		return 31'(v);
	endfunction

	task automatic random_cmd();
		int k;
		k = $urandom_range(0, 99);
		if (k < 25) send_cmd(nrts_pkg::OP_FBEG, 0, 0, 0, 0, pick_position());
		else if (k < 50) send_cmd(nrts_pkg::OP_FEND, 0, 0, 0, 0, pick_position());
		else if (k < 75) send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, pick_position());
		else if (k < 82) send_cmd(nrts_pkg::OP_RESET);
		else if (k < 90) send_cmd(nrts_pkg::OP_NEXT);
		else if (k < 96) send_cmd(nrts_pkg::OP_WRITE,
			12'($urandom_range(0, nrts_pkg::DEPTH - 1)), 31'($urandom), 31'($urandom),
			1'($urandom_range(0, 1)));
		else send_cmd($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, 12'($urandom),
			31'($urandom), 31'($urandom), 1'($urandom_range(0, 1)), 31'($urandom));
	endtask

	task automatic test_directed();
		send_cmd(nrts_pkg::OP_WRITE, 0, 10, 50, 0);
		send_cmd(nrts_pkg::OP_WRITE, 1, 12, 20, 1);
		send_cmd(nrts_pkg::OP_WRITE, 2, 15, 15, 1);
		send_cmd(nrts_pkg::OP_WRITE, 3, 30, 40, 1);
		send_cmd(nrts_pkg::OP_WRITE, 4, 60, 60, 0);
		send_cmd(nrts_pkg::OP_WRITE, 5, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
		set_count(13'd6);
		for (int i = 0; i < 7; i++) send_cmd(nrts_pkg::OP_NEXT);
		send_cmd(nrts_pkg::OP_FBEG, 0, 0, 0, 0, 12);
		send_cmd(nrts_pkg::OP_RESET);
		send_cmd(nrts_pkg::OP_FBEG, 0, 0, 0, 0, 12);
		send_cmd(nrts_pkg::OP_FEND, 0, 0, 0, 0, 35);
		send_cmd(nrts_pkg::OP_FEND, 0, 0, 0, 0, 31'd2147483646);
		send_cmd(nrts_pkg::OP_RESET);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 0);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 14);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 16);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 59);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 60);
		send_cmd(nrts_pkg::OP_CONT, 0, 0, 0, 0, 31'd2147483646);
		send_cmd(OP_SPARE6);
		send_cmd(OP_SPARE7);
		send_cmd(nrts_pkg::OP_WRITE, 12'hFFF, 31'h7FFFFFFF, 0, 1);
		send_cmd(nrts_pkg::OP_FBEG, 0, 0, 0, 0, 55);
		set_count(13'd2);
		send_cmd(nrts_pkg::OP_NEXT);
		set_count(13'd0);
		send_cmd(nrts_pkg::OP_NEXT);
	endtask

	task automatic test_full_table();
		build_table(120);
		set_count(13'd120);
		send_cmd(nrts_pkg::OP_RESET);
		for (int i = 0; i < 40; i++) random_cmd();
	endtask

	task automatic test_random();
		int n;
		for (int ph = 0; ph < 8; ph++) begin
			quiet = ph == 5;
			n = $urandom_range(1, 24);
			build_table(n);
			set_count(13'(n));
			for (int i = 0; i < 20; i++) random_cmd();
		end
		quiet = 0;
	endtask

	always @(posedge clk) begin
		lookup_t x;
		if (done) begin
			if (lookups_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
			end else begin
				x = lookups_due.pop_front();
				if (range_begin !== x.rbeg || range_end !== x.rend
						|| cursor_index !== x.cidx || exhausted !== x.ex
						|| found !== x.fnd || found_index !== x.fidx) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp %h %h %0d %b %b %0d got %h %h %0d %b %b %0d",
							$time, x.rbeg, x.rend, x.cidx, x.ex, x.fnd, x.fidx,
							range_begin, range_end, cursor_index, exhausted, found,
							found_index);
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("[nested_range_table_search] ERROR");
		$finish;
	end

	initial begin
		mismatches = 0;
		quiet = 0;
		cur_pos = 0;
		range_cnt = 1;
		for (int i = 0; i < nrts_pkg::DEPTH; i++) begin
			tbl_beg[i] = 0;
			tbl_end[i] = 0;
			tbl_nst[i] = 0;
		end
		arst_n = 1'b0;
		start = 1'b0;
		op = nrts_pkg::OP_WRITE;
		entry_index = '0;
		entry_begin = '0;
		entry_end = '0;
		entry_nested = 1'b0;
		position = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_table();
		test_random();
		while (lookups_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && lookups_due.size() == 0) begin
			$display("[nested_range_table_search] OK");
		end else begin
			$display("[nested_range_table_search] ERROR");
		end
		$finish;
	end
endmodule
